### rtl/fss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

  // Field and register widths.
  localparam int unsigned HAY_W      = 8;
  localparam int unsigned HIT_W      = 16;
  localparam int unsigned SCORE_W    = 19;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CHARS_PER_REG = CFG_W / HAY_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_A       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_B       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_C       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_D       = 3'd4;

  // Parameter defaults.
  localparam int unsigned NEEDLE_MAX_DFLT      = 32;
  localparam int unsigned HITS_TABLE_SIZE_DFLT = 1024;

  // Score accumulation, in tenths.
  localparam int unsigned TENTHS_W   = 10;
  localparam int unsigned TENTHS_MAX = 1023;
  localparam int unsigned RAW_W      = 11;
  localparam int unsigned ADD_W      = 5;
  localparam int unsigned BONUS_MATCH  = 10;
  localparam int unsigned BONUS_CONSEC = 5;
  localparam int unsigned BONUS_SEP    = 8;
  localparam int unsigned BONUS_CAMEL  = 6;
  localparam int unsigned BONUS_FIRST  = 5;

  // Final score arithmetic.
  localparam int unsigned DIV_W      = 9;
  localparam int unsigned MULT_W     = 18;
  localparam int unsigned PROD_W     = RAW_W + MULT_W;
  localparam int unsigned LOG_FRAC_W = 32;
  localparam int unsigned MID_W      = 47;
  localparam int unsigned Q16_ONE    = 65536;
  localparam int unsigned SCORE_MAX  = 524287;
  // 0.3 * log10(2) * 65536 in Q32, split into integer and fraction words.
  localparam int unsigned K_HI       = 5918;
  localparam int unsigned K_LO       = 2106847890;
  localparam int unsigned ROUND_HALF = 32'h8000_0000;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_MATCH,
    KIND_MISS
  } kind_e;

  // One finished entry, handed from the front end to the back end.
  typedef struct packed {
    kind_e                kind;
    logic [RAW_W-1:0]     raw;
    logic [HIT_W-1:0]     hits;
    logic [DIV_W-1:0]     divisor;
  } job_t;

endpackage

`default_nettype wire

### rtl/fss_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fss_in_if import fss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HAY_W-1:0] hay_char;
  logic             end_of_entry;
  logic [HIT_W-1:0] hit_count;

  modport source (output valid, hay_char, end_of_entry, hit_count, input ready);
  modport sink (input valid, hay_char, end_of_entry, hit_count, output ready);
endinterface

`default_nettype wire

### rtl/fss_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fss_out_if import fss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score_q16;
  logic               matched;

  modport source (output valid, score_q16, matched, input ready);
  modport sink (input valid, score_q16, matched, output ready);
endinterface

`default_nettype wire

### rtl/fss_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fss_front import fss_pkg::*; #(
  parameter int unsigned NEEDLE_MAX      = NEEDLE_MAX_DFLT,
  parameter int unsigned HITS_TABLE_SIZE = HITS_TABLE_SIZE_DFLT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  fss_in_if.sink                    item_i,
  output job_t                      job_o,
  output logic                      job_valid_o,
  input  wire logic                 job_ready_i
);

  localparam int unsigned IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

  function automatic logic [HAY_W-1:0] fold_case(input logic [HAY_W-1:0] c);
    if (c inside {[8'h41:8'h5a]}) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // Dash, underscore, period, space, slash and backslash.
  function automatic logic is_sep(input logic [HAY_W-1:0] c);
    return c inside {8'h2d, 8'h5f, 8'h2e, 8'h20, 8'h2f, 8'h5c};
  endfunction

  logic [LEN_W-1:0] needle_length_q;
  logic [HAY_W-1:0] needle_q [NEEDLE_MAX];

  logic [LEN_W-1:0]    match_index_q, match_index_d;
  logic                last_match_q, last_match_d;
  logic [HAY_W-1:0]    prev_char_q, prev_char_d;
  logic                at_start_q, at_start_d;
  logic                first_zero_q, first_zero_d;
  logic [TENTHS_W-1:0] tenths_q, tenths_d;

  logic [LEN_W-1:0]    len_eff;
  logic [HAY_W-1:0]    hay;
  logic [HAY_W-1:0]    nchar;
  logic                hit;
  logic [ADD_W-1:0]    add;
  logic [RAW_W-1:0]    tenths_sum;
  logic [TENTHS_W-1:0] tenths_upd;
  logic [LEN_W-1:0]    index_upd;
  logic                first_upd;
  logic                accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_length_q <= '0;
      for (int j = 0; j < NEEDLE_MAX; j++) begin
        needle_q[j] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_NEEDLE_LENGTH) begin
        needle_length_q <= cfg_wdata_i[LEN_W-1:0];
      end
      for (int j = 0; j < NEEDLE_MAX; j++) begin
        if (cfg_idx_i == CFG_IDX_W'(int'(REG_CHARS_A) + j / CHARS_PER_REG)) begin
          needle_q[j] <= cfg_wdata_i[HAY_W*(j % CHARS_PER_REG) +: HAY_W];
        end
      end
    end
  end

  assign accept       = item_i.valid && item_i.ready;
  assign item_i.ready = job_ready_i;

  always_comb begin
    hay     = item_i.hay_char;
    len_eff = needle_length_q;
    if (needle_length_q > LEN_W'(NEEDLE_MAX)) begin
      len_eff = LEN_W'(NEEDLE_MAX);
    end
    nchar = needle_q[match_index_q[IDX_W-1:0]];
    hit   = (match_index_q < len_eff) && (fold_case(nchar) == fold_case(hay));

    add = '0;
    if (hit) begin
      add = ADD_W'(BONUS_MATCH);
      if (last_match_q) begin
        add = add + ADD_W'(BONUS_CONSEC);
      end
      if (!at_start_q) begin
        if (is_sep(prev_char_q)) begin
          add = add + ADD_W'(BONUS_SEP);
        end else if ((hay inside {[8'h41:8'h5a]}) && (prev_char_q inside {[8'h61:8'h7a]})) begin
          add = add + ADD_W'(BONUS_CAMEL);
        end
      end
    end
    tenths_sum = RAW_W'(tenths_q) + RAW_W'(add);
    tenths_upd = (tenths_sum > RAW_W'(TENTHS_MAX)) ? TENTHS_W'(TENTHS_MAX)
                                                   : tenths_sum[TENTHS_W-1:0];
    index_upd  = hit ? match_index_q + 1'b1 : match_index_q;
    first_upd  = first_zero_q || (hit && at_start_q);

    match_index_d = match_index_q;
    last_match_d  = last_match_q;
    prev_char_d   = prev_char_q;
    at_start_d    = at_start_q;
    first_zero_d  = first_zero_q;
    tenths_d      = tenths_q;
    if (accept) begin
      if (item_i.end_of_entry) begin
        match_index_d = '0;
        last_match_d  = 1'b0;
        prev_char_d   = '0;
        at_start_d    = 1'b1;
        first_zero_d  = 1'b0;
        tenths_d      = '0;
      end else begin
        match_index_d = index_upd;
        last_match_d  = hit;
        prev_char_d   = hay;
        at_start_d    = 1'b0;
        first_zero_d  = first_upd;
        tenths_d      = tenths_upd;
      end
    end

    job_valid_o = accept && item_i.end_of_entry;
    if (len_eff == '0) begin
      job_o.kind = KIND_EMPTY;
    end else if (index_upd >= len_eff) begin
      job_o.kind = KIND_MATCH;
    end else begin
      job_o.kind = KIND_MISS;
    end
    job_o.raw = RAW_W'(tenths_upd) + (first_upd ? RAW_W'(BONUS_FIRST) : RAW_W'(0));
    if (32'(item_i.hit_count) > HITS_TABLE_SIZE - 1) begin
      job_o.hits = HIT_W'(HITS_TABLE_SIZE - 1);
    end else begin
      job_o.hits = item_i.hit_count;
    end
    job_o.divisor = DIV_W'((DIV_W'(len_eff) + DIV_W'(1)) * DIV_W'(10));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_index_q <= '0;
      last_match_q  <= 1'b0;
      prev_char_q   <= '0;
      at_start_q    <= 1'b1;
      first_zero_q  <= 1'b0;
      tenths_q      <= '0;
    end else begin
      match_index_q <= match_index_d;
      last_match_q  <= last_match_d;
      prev_char_q   <= prev_char_d;
      at_start_q    <= at_start_d;
      first_zero_q  <= first_zero_d;
      tenths_q      <= tenths_d;
    end
  end

  // The match position never runs past the longest possible needle.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_index_q <= LEN_W'(NEEDLE_MAX))
    else $error("match index beyond needle");

endmodule

`default_nettype wire

### rtl/fss_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fss_queue import fss_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      job_o,
  output logic      valid_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entries_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // The front end only finishes an entry while there is room for it.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

endmodule

`default_nettype wire

### rtl/fss_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fss_back import fss_pkg::*; #(
  parameter int unsigned HITS_TABLE_SIZE = HITS_TABLE_SIZE_DFLT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  job_t      job_i,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  fss_out_if.source result_o
);

  localparam int unsigned X_W    = $clog2(HITS_TABLE_SIZE + 1);
  localparam int unsigned K_W    = $clog2(X_W);
  localparam int unsigned SH_W   = $clog2(LOG_FRAC_W);
  localparam int unsigned SQ_W   = 2 * LOG_FRAC_W;
  localparam int unsigned STEP_W = $clog2((LOG_FRAC_W > PROD_W) ? LOG_FRAC_W : PROD_W);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_NORM = 4'd1;
  localparam logic [3:0] ST_LOG  = 4'd2;
  localparam logic [3:0] ST_LOW  = 4'd3;
  localparam logic [3:0] ST_MID  = 4'd4;
  localparam logic [3:0] ST_MULT = 4'd5;
  localparam logic [3:0] ST_PROD = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [RAW_W-1:0]      raw_q, raw_d;
  logic [X_W-1:0]        x_q, x_d;
  logic [DIV_W-1:0]      div_q, div_d;
  logic [K_W-1:0]        lh_q, lh_d;
  logic [LOG_FRAC_W-1:0] m_q, m_d;
  logic [LOG_FRAC_W-1:0] frac_q, frac_d;
  logic [SQ_W-1:0]       low_q, low_d;
  logic [MID_W-1:0]      mid_q, mid_d;
  logic [MULT_W-1:0]     mult_q, mult_d;
  logic [PROD_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic                  match_q, match_d;

  logic                  out_valid_q, out_valid_d;
  logic [SCORE_W-1:0]    out_score_q, out_score_d;
  logic                  out_match_q, out_match_d;

  logic [K_W-1:0]        lead;
  logic [SH_W-1:0]       shamt;
  logic [SQ_W-1:0]       sq_full;
  logic [LOG_FRAC_W:0]   sq_top;
  logic [MID_W-1:0]      mid_full;
  logic [DIV_W:0]        trial;
  logic                  load_out;

  assign job_ready_o = (state_q == ST_IDLE);
  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  always_comb begin
    lead = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x_q[i]) begin
        lead = K_W'(i);
      end
    end
    shamt    = SH_W'(LOG_FRAC_W - 1) - SH_W'(lead);
    sq_full  = SQ_W'(m_q) * SQ_W'(m_q);
    sq_top   = sq_full[SQ_W-1:LOG_FRAC_W-1];
    mid_full = mid_q + MID_W'(lh_q) * MID_W'(K_LO);
    trial    = {rem_q, quo_q[PROD_W-1]};
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    raw_d   = raw_q;
    x_d     = x_q;
    div_d   = div_q;
    lh_d    = lh_q;
    m_d     = m_q;
    frac_d  = frac_q;
    low_d   = low_q;
    mid_d   = mid_q;
    mult_d  = mult_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    match_d = match_q;

    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          raw_d   = job_i.raw;
          x_d     = X_W'(job_i.hits) + X_W'(1);
          div_d   = job_i.divisor;
          case (job_i.kind)
            KIND_EMPTY: begin
              quo_d   = PROD_W'(Q16_ONE);
              match_d = 1'b1;
              state_d = ST_DONE;
            end
            KIND_MATCH: begin
              match_d = 1'b1;
              state_d = ST_NORM;
            end
            default: begin
              quo_d   = '0;
              match_d = 1'b0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_NORM: begin
        m_d     = LOG_FRAC_W'(x_q) << shamt;
        lh_d    = lead;
        frac_d  = '0;
        step_d  = '0;
        state_d = ST_LOG;
      end
      ST_LOG: begin
        if (sq_top[LOG_FRAC_W]) begin
          m_d    = sq_top[LOG_FRAC_W:1];
          frac_d = {frac_q[LOG_FRAC_W-2:0], 1'b1};
        end else begin
          m_d    = sq_top[LOG_FRAC_W-1:0];
          frac_d = {frac_q[LOG_FRAC_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(LOG_FRAC_W - 1)) begin
          state_d = ST_LOW;
        end
      end
      ST_LOW: begin
        low_d   = SQ_W'(frac_q) * SQ_W'(K_LO);
        state_d = ST_MID;
      end
      ST_MID: begin
        mid_d   = MID_W'(frac_q) * MID_W'(K_HI) + MID_W'(low_q[SQ_W-1:LOG_FRAC_W])
                + MID_W'(ROUND_HALF);
        state_d = ST_MULT;
      end
      ST_MULT: begin
        mult_d  = MULT_W'(MID_W'(Q16_ONE) + MID_W'(lh_q) * MID_W'(K_HI)
                + (mid_full >> LOG_FRAC_W));
        state_d = ST_PROD;
      end
      ST_PROD: begin
        quo_d   = PROD_W'(raw_q) * PROD_W'(mult_q);
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (trial >= (DIV_W + 1)'(div_q)) begin
          rem_d = DIV_W'(trial - (DIV_W + 1)'(div_q));
          quo_d = {quo_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = trial[DIV_W-1:0];
          quo_d = {quo_q[PROD_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(PROD_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_score_d = out_score_q;
    out_match_d = out_match_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_match_d = match_q;
      out_score_d = (quo_q > PROD_W'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX)
                                                : quo_q[SCORE_W-1:0];
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q       <= raw_d;
    x_q         <= x_d;
    div_q       <= div_d;
    lh_q        <= lh_d;
    m_q         <= m_d;
    frac_q      <= frac_d;
    low_q       <= low_d;
    mid_q       <= mid_d;
    mult_q      <= mult_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    match_q     <= match_d;
    out_score_q <= out_score_d;
    out_match_q <= out_match_d;
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.score_q16 = out_score_q;
  assign result_o.matched   = out_match_q;

  // Repeated squaring keeps the mantissa normalized to [1, 2).
  a_log_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOG |-> m_q[LOG_FRAC_W-1])
    else $error("log mantissa lost normalization");

  // The divider never sees a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_q != '0)
    else $error("zero divisor in divider");

  // A candidate that did not match always reports a zero score.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_match_q |-> out_score_q == '0)
    else $error("nonzero score on a miss");

endmodule

`default_nettype wire

### rtl/fuzzy_subsequence_scorer.sv
// Fuzzy subsequence scorer.
//
// Items arrive on item_i, one candidate byte per item, with end_of_entry set
// on the last byte of a candidate and hit_count sampled on that byte. Each
// byte is compared case-insensitively with the next unmatched needle
// character in the front end, which accepts one item per cycle while the
// queue has room. The last byte of a candidate hands a finished entry
// to a two-deep queue; the back end turns it into one result on result_o.
// The needle must be loaded through the write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) while the block is idle; the block does not enforce this.
// After its last byte is accepted, a matched candidate goes through
// normalize, 32 squaring steps of the log unit, three steps of the scale
// multiply, one product and a 29-step restoring divider; empty needles
// and misses skip these steps and go straight to the output register.
// Bytes stream at one per cycle while the queue has room; the back end
// takes a new entry only after the previous result entered the output register.
// Reset clears the needle, the length and the running match state.
// When the receiver holds ready low the result waits in the output register,
// the back end stops, and once the queue fills the front end drops ready.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_subsequence_scorer import fss_pkg::*; #(
  parameter int unsigned NEEDLE_MAX      = NEEDLE_MAX_DFLT,
  parameter int unsigned HITS_TABLE_SIZE = HITS_TABLE_SIZE_DFLT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  fss_in_if.sink                    item_i,
  fss_out_if.source                 result_o
);

  // Finished entries travel from the byte matcher to the score unit.
  job_t front_job;
  logic front_job_valid;
  job_t queue_job;
  logic queue_full;
  logic queue_valid;
  logic back_ready;

  fss_front #(
    .NEEDLE_MAX      (NEEDLE_MAX),
    .HITS_TABLE_SIZE (HITS_TABLE_SIZE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .job_o       (front_job),
    .job_valid_o (front_job_valid),
    .job_ready_i (!queue_full)
  );

  // The queue lets the matcher keep taking bytes while the score unit works.
  fss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_job_valid),
    .job_i   (front_job),
    .full_o  (queue_full),
    .pop_i   (back_ready),
    .job_o   (queue_job),
    .valid_o (queue_valid)
  );

  // The score unit computes the hit-count multiplier and the final division.
  fss_back #(
    .HITS_TABLE_SIZE (HITS_TABLE_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (queue_job),
    .job_valid_i (queue_valid),
    .job_ready_o (back_ready),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

### verif/fuzzy_subsequence_scorer_test.sv
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_test;
  import fss_pkg::*;

  // Clocking, reset and run length.
  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 6;
  localparam int ITEM_TARGET  = 600;
  // Over the last items of the run there are no random idle or stall bursts.
  localparam int TAIL_ITEMS   = 80;
  // This margin covers the slowest entry in the back end plus the queue in
  // front of it.
  localparam int DRAIN_CYCLES = 300;
  localparam int END_WAIT     = 20000;
  localparam int TIMEOUT_NS   = 20_000_000;

  // Scoring rules, in tenths of a point.
  localparam int unsigned PTS_MATCH     = 10;
  localparam int unsigned PTS_RUN       = 5;
  localparam int unsigned PTS_SEPARATOR = 8;
  localparam int unsigned PTS_CAMEL     = 6;
  localparam int unsigned PTS_FIRST     = 5;
  localparam int unsigned TENTHS_CAP    = 1023;
  localparam int unsigned NEEDLE_CAP    = 32;
  localparam int unsigned HITS_CAP      = 1023;
  localparam longint unsigned Q16_UNITY = 65536;
  localparam longint unsigned SCORE_CAP = 524287;
  // 0.3 * log10(2) * 2^16, held in Q32 as an integer word and a fraction word.
  localparam longint unsigned LOG2_SCALE_INT  = 5918;
  localparam longint unsigned LOG2_SCALE_FRAC = 2106847890;

  localparam logic [CFG_W-1:0] NEEDLE_ALL_A = {8{8'h61}};

  typedef struct packed {
    logic [HAY_W-1:0] hay_char;
    logic             end_of_entry;
    logic [HIT_W-1:0] hit_count;
  } hay_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score_q16;
    logic               matched;
  } score_t;

  typedef enum logic {ROW_LOAD, ROW_BYTE} row_kind_e;

  // One row of the directed plan: either a needle load (length, the word for
  // characters 0 to 7, and one word repeated for the other three registers)
  // or one candidate byte. A byte row may carry a hand-written expectation.
  typedef struct packed {
    row_kind_e        kind;
    logic [LEN_W-1:0] len;
    logic [CFG_W-1:0] word_a;
    logic [CFG_W-1:0] word_rest;
    hay_item_t        item;
    logic             typed;
    score_t           want;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN [26] = '{
    // Straight out of reset the needle is empty, so every candidate scores 1.0.
    '{ROW_BYTE, 0, 0, 0, '{"x", 1, 0}, 1, '{65536, 1}},
    '{ROW_BYTE, 0, 0, 0, '{8'hFF, 1, 16'hFFFF}, 1, '{65536, 1}},
    '{ROW_BYTE, 0, 0, 0, '{8'h00, 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"q", 1, 16'h5A5A}, 1, '{65536, 1}},
    // Needle "aBc". First byte match, a camel-case match and a run.
    '{ROW_LOAD, 3, 64'h0063_4261, 0, '{0, 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"A", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"x", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"B", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"c", 1, 1023}, 0, '{0, 0}},
    // Matches after separators, and a run into an uppercase byte.
    '{ROW_BYTE, 0, 0, 0, '{"-", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"a", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"_", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"b", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"C", 1, 16'hFFFF}, 0, '{0, 0}},
    // A candidate that misses gives a zero result.
    '{ROW_BYTE, 0, 0, 0, '{"q", 1, 7}, 1, '{0, 0}},
    // Bytes after the whole needle has matched are ignored.
    '{ROW_BYTE, 0, 0, 0, '{"a", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"b", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"c", 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"a", 1, 0}, 0, '{0, 0}},
    // Lengths above the needle capacity count as a full 32-character needle.
    '{ROW_LOAD, 63, NEEDLE_ALL_A, NEEDLE_ALL_A, '{0, 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{"A", 1, 16'hFFFF}, 1, '{0, 0}},
    '{ROW_LOAD, 33, 0, 0, '{0, 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{8'h00, 1, 0}, 1, '{0, 0}},
    // One-character needle of 0xFF. Case folding covers only A to Z.
    '{ROW_LOAD, 1, 64'hFF, {CFG_W{1'b1}}, '{0, 0, 0}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{8'hFF, 1, 1024}, 0, '{0, 0}},
    '{ROW_BYTE, 0, 0, 0, '{8'hDF, 1, 0}, 1, '{0, 0}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  fss_in_if  item_if ();
  fss_out_if res_if ();

  fuzzy_subsequence_scorer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .item_i     (item_if),
    .result_o   (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Scores still owed by the block, oldest first.
  score_t score_queue [$];
  int     mismatch_count = 0;
  int     items_sent     = 0;
  // Set near the end of the run. From then on no random idle or stall bursts.
  bit     steady_tail    = 1'b0;

  // Shadow copy of the needle registers.
  logic [LEN_W-1:0]        needle_len   = '0;
  logic [3:0][CFG_W-1:0]   needle_words = '0;

  // Per-candidate scan state. It returns to these values after every
  // last byte of a candidate.
  int unsigned scan_pos           = 0;
  bit          scan_prev_hit      = 1'b0;
  logic [7:0]  scan_prev_char     = 8'h00;
  bit          scan_at_start      = 1'b1;
  bit          scan_first_at_zero = 1'b0;
  int unsigned scan_tenths        = 0;

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_upper(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic bit is_lower(input logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic bit is_separator(input logic [7:0] c);
    return c == "-" || c == "_" || c == "." || c == " " || c == "/" || c == "\\";
  endfunction

  function automatic logic [7:0] needle_at(input int unsigned j);
    return needle_words[(j >> 3) & 3][8 * (j & 7) +: 8];
  endfunction

  // Q16 weight for a usage count: 1 + 0.3 * log10(x), rounded. log2(x) is
  // built with 32 fraction bits by repeated squaring of the mantissa, then
  // scaled by the Q32 constant with rounding half up.
  function automatic longint unsigned usage_weight(input int unsigned x);
    int unsigned     k;
    longint unsigned m, frac, mid, low;
    k = 0;
    frac = 0;
    if (x == 0) x = 1;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = 64'(x) << (31 - k);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    mid = 64'(k) * LOG2_SCALE_FRAC + frac * LOG2_SCALE_INT;
    low = frac * LOG2_SCALE_FRAC;
    mid = mid + ((low + 64'h8000_0000_0000_0000) >> 32);
    return Q16_UNITY + 64'(k) * LOG2_SCALE_INT + (mid >> 32);
  endfunction

  // Advances the scan by one candidate byte. Returns 1 with the score when
  // the byte closes a candidate.
  function automatic bit predict_score(input hay_item_t it, output score_t res);
    int unsigned     eff_len, add, hits;
    longint unsigned raw, score;
    bit              hit_now;
    eff_len = (needle_len > NEEDLE_CAP) ? NEEDLE_CAP : needle_len;
    hit_now = 1'b0;
    res = '0;
    if (scan_pos < eff_len && lower_case(needle_at(scan_pos)) == lower_case(it.hay_char)) begin
      add = PTS_MATCH;
      hit_now = 1'b1;
      if (scan_at_start) scan_first_at_zero = 1'b1;
      if (scan_prev_hit) add += PTS_RUN;
      if (!scan_at_start) begin
        if (is_separator(scan_prev_char)) begin
          add += PTS_SEPARATOR;
        end else if (is_upper(it.hay_char) && is_lower(scan_prev_char)) begin
          add += PTS_CAMEL;
        end
      end
      scan_tenths = (scan_tenths + add > TENTHS_CAP) ? TENTHS_CAP : scan_tenths + add;
      scan_pos = (scan_pos + 1) & 63;
    end
    scan_prev_hit = hit_now;
    scan_prev_char = it.hay_char;
    scan_at_start = 1'b0;
    if (!it.end_of_entry) return 1'b0;

    if (eff_len == 0) begin
      // An empty needle matches everything with a score of exactly one.
      res.score_q16 = SCORE_W'(Q16_UNITY);
      res.matched = 1'b1;
    end else if (scan_pos >= eff_len) begin
      raw = 64'(scan_tenths) + (scan_first_at_zero ? 64'(PTS_FIRST) : 64'd0);
      hits = (it.hit_count > HITS_CAP) ? HITS_CAP : it.hit_count;
      score = raw * usage_weight(hits + 1) / (64'd10 * (64'(eff_len) + 64'd1));
      if (score > SCORE_CAP) score = SCORE_CAP;
      res.score_q16 = SCORE_W'(score);
      res.matched = 1'b1;
    end
    scan_pos = 0;
    scan_prev_hit = 1'b0;
    scan_prev_char = 8'h00;
    scan_at_start = 1'b1;
    scan_first_at_zero = 1'b0;
    scan_tenths = 0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] separator_byte();
    case ($urandom_range(0, 5))
      0: return "-";
      1: return "_";
      2: return ".";
      3: return " ";
      4: return "/";
      default: return "\\";
    endcase
  endfunction

  // Needle characters come mostly from a small alphabet so that noise bytes
  // collide with them now and then.
  function automatic logic [7:0] needle_byte();
    case ($urandom_range(0, 5))
      0, 1, 2: return 8'("a" + $urandom_range(0, 5));
      3: return 8'("A" + $urandom_range(0, 5));
      4: return separator_byte();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic hay_item_t noise_item();
    hay_item_t it;
    case ($urandom_range(0, 3))
      0: it.hay_char = separator_byte();
      1: it.hay_char = 8'("a" + $urandom_range(0, 7));
      2: it.hay_char = 8'("A" + $urandom_range(0, 7));
      default: it.hay_char = 8'($urandom_range(0, 255));
    endcase
    it.end_of_entry = 1'b0;
    it.hit_count = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  // Usage counts: zero, the top of the field, the region around the
  // saturation point, small counts and anything at all.
  function automatic logic [HIT_W-1:0] pick_hit_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'($urandom_range(1000, 1100));
      3, 4: return 16'($urandom_range(0, 63));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offers one byte to the block, with an occasional idle burst first, and
  // books the expected score when the byte closes a candidate.
  task automatic send_byte(input hay_item_t it, input bit typed, input score_t want);
    score_t res;
    if (!steady_tail && $urandom_range(0, 7) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_if.valid        <= 1'b1;
    item_if.hay_char     <= it.hay_char;
    item_if.end_of_entry <= it.end_of_entry;
    item_if.hit_count    <= it.hit_count;
    @(posedge clk);
    while (item_if.ready !== 1'b1) @(posedge clk);
    if (predict_score(it, res)) score_queue.push_back(typed ? want : res);
    items_sent++;
    if (items_sent >= ITEM_TARGET - TAIL_ITEMS) steady_tail = 1'b1;
  endtask

  // Lets the block run dry before the needle is touched: every owed score
  // must have come out, and the back end gets time to finish anything it
  // still holds.
  task automatic settle_block();
    item_if.valid <= 1'b0;
    while (score_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the length and all four character words on back-to-back cycles.
  task automatic load_needle(input logic [LEN_W-1:0] len, input logic [3:0][CFG_W-1:0] words);
    logic [CFG_IDX_W-1:0] char_reg [4];
    char_reg = '{REG_CHARS_A, REG_CHARS_B, REG_CHARS_C, REG_CHARS_D};
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_NEEDLE_LENGTH;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk);
    for (int r = 0; r < 4; r++) begin
      cfg_idx   <= char_reg[r];
      cfg_wdata <= words[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    needle_len = len;
    needle_words = words;
  endtask

  // One random needle followed by a handful of candidates. Most candidates
  // carry the needle in order, with random case and noise in between. Some
  // lose one needle character and some are pure noise.
  task automatic run_random_phase();
    int unsigned           len, eff_len, shape, drop_at;
    logic [7:0]            chars [32];
    logic [3:0][CFG_W-1:0] words;
    hay_item_t             cand [$];
    hay_item_t             it;
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = NEEDLE_CAP;
      2: len = $urandom_range(NEEDLE_CAP + 1, 63);
      default: len = $urandom_range(1, 8);
    endcase
    for (int j = 0; j < 32; j++) begin
      chars[j] = needle_byte();
      words[j / 8][8 * (j % 8) +: 8] = chars[j];
    end
    settle_block();
    load_needle(LEN_W'(len), words);
    eff_len = (len > NEEDLE_CAP) ? NEEDLE_CAP : len;

    repeat ($urandom_range(4, 10)) begin
      cand.delete();
      shape = $urandom_range(0, 9);
      if (shape >= 8) begin
        repeat ($urandom_range(1, 12)) cand.push_back(noise_item());
      end else begin
        drop_at = (shape == 7) ? $urandom_range(0, eff_len) : eff_len;
        for (int j = 0; j < eff_len; j++) begin
          if (j == drop_at) continue;
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) cand.push_back(noise_item());
          end
          it = noise_item();
          it.hay_char = chars[j];
          if ((is_upper(it.hay_char) || is_lower(it.hay_char)) && $urandom_range(0, 1) == 1) begin
            it.hay_char = it.hay_char ^ 8'h20;
          end
          cand.push_back(it);
        end
        repeat ($urandom_range(0, 3)) cand.push_back(noise_item());
      end
      if (cand.size() == 0) cand.push_back(noise_item());
      it = cand[cand.size() - 1];
      it.end_of_entry = 1'b1;
      it.hit_count = pick_hit_count();
      cand[cand.size() - 1] = it;
      foreach (cand[k]) send_byte(cand[k], 1'b0, '0);
    end
  endtask

  // Result side. Ready comes in random runs with stall bursts, and stays high
  // once the run is in its tail.
  initial begin : result_sink
    int unsigned hold;
    res_if.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        hold = $urandom_range(0, 15);
      end else begin
        res_if.ready <= 1'b1;
        hold = $urandom_range(0, 31);
      end
    end
  end

  // Every result item taken by the sink is compared with the oldest owed score.
  always @(posedge clk) begin : score_check
    score_t want;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (score_queue.size() == 0) begin
        $display("%0t: unexpected result item, score_q16 %0d matched %0b",
                 $time, res_if.score_q16, res_if.matched);
        mismatch_count++;
      end else begin
        want = score_queue.pop_front();
        if (res_if.score_q16 !== want.score_q16) begin
          $display("%0t: score_q16 expected %0d, got %0d",
                   $time, want.score_q16, res_if.score_q16);
          mismatch_count++;
        end
        if (res_if.matched !== want.matched) begin
          $display("%0t: matched expected %0b, got %0b",
                   $time, want.matched, res_if.matched);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [3:0][CFG_W-1:0] words;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_NEEDLE_LENGTH;
    cfg_wdata = '0;
    item_if.valid = 1'b0;
    item_if.hay_char = '0;
    item_if.end_of_entry = 1'b0;
    item_if.hit_count = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan. Needle loads wait for the block to go idle.
    foreach (DIRECTED_PLAN[r]) begin
      if (DIRECTED_PLAN[r].kind == ROW_LOAD) begin
        words = {DIRECTED_PLAN[r].word_rest, DIRECTED_PLAN[r].word_rest,
                 DIRECTED_PLAN[r].word_rest, DIRECTED_PLAN[r].word_a};
        settle_block();
        load_needle(DIRECTED_PLAN[r].len, words);
      end else begin
        send_byte(DIRECTED_PLAN[r].item, DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
      end
    end

    while (items_sent < ITEM_TARGET) run_random_phase();

    // Wait, with a bound, for the last owed scores, then give the back end
    // time to show any stray result item.
    item_if.valid <= 1'b0;
    for (int c = 0; c < END_WAIT && score_queue.size() != 0; c++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (score_queue.size() != 0) begin
      $display("%0t: %0d expected result items never arrived", $time, score_queue.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t: run timed out", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
